// ===== hw/rtl/integer_expression_alu_top_macros.svh =====
// assertion macros for the integer expression alu
// used by integer_expression_alu_top.sv, needs i_clk and i_rst_n in scope
`ifndef INTEGER_EXPRESSION_ALU_TOP_MACROS_SVH
`define INTEGER_EXPRESSION_ALU_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define IEA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define IEA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/iea_pkg.sv =====
// shared types for the integer expression alu
// no dependencies, compiled first
`default_nettype none

package iea_pkg;

    localparam int KIND_W = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD  = 4'd0,
        KIND_SUB  = 4'd1,
        KIND_MUL  = 4'd2,
        KIND_DIV  = 4'd3,
        KIND_LT   = 4'd4,
        KIND_LE   = 4'd5,
        KIND_EQ   = 4'd6,
        KIND_NE   = 4'd7,
        KIND_GT   = 4'd8,
        KIND_GE   = 4'd9,
        KIND_LOR  = 4'd10,
        KIND_LAND = 4'd11,
        KIND_OR   = 4'd12,
        KIND_AND  = 4'd13,
        KIND_XOR  = 4'd14,
        KIND_NOT  = 4'd15
    } t_kind;

    // control that travels with each item down the pipe
    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  neg;   // quotient sign
        logic  dz;    // division with zero divisor
    } t_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/iea_in_if.sv =====
// operation channel: valid/ready plus opcode and two operands
// depends on iea_pkg
`default_nettype none

interface iea_in_if import iea_pkg::*; #(
    parameter int DATA_WIDTH = 32
) ();
    logic                         valid;
    logic                         ready;
    logic [KIND_W-1:0]            kind;
    logic signed [DATA_WIDTH-1:0] left_operand;
    logic signed [DATA_WIDTH-1:0] right_operand;

    modport source (output valid, kind, left_operand, right_operand, input ready);
    modport sink   (input valid, kind, left_operand, right_operand, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/iea_out_if.sv =====
// result channel: valid/ready plus value and divide-by-zero flag
// no dependencies
`default_nettype none

interface iea_out_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         divide_by_zero;

    modport source (output valid, value, divide_by_zero, input ready);
    modport sink   (input valid, value, divide_by_zero, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/iea_front.sv =====
// front end: input register, simple ops, split multiplier, divide prep
// depends on iea_pkg
`default_nettype none

module iea_front import iea_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire t_kind                        i_kind,
    input  wire logic signed [DATA_WIDTH-1:0] i_a,
    input  wire logic signed [DATA_WIDTH-1:0] i_b,
    output t_ctl                              o_ctl,
    output logic [DATA_WIDTH-1:0]             o_fast,
    output logic [DATA_WIDTH-1:0]             o_mag_a,
    output logic [DATA_WIDTH-1:0]             o_mag_b
);

    localparam int HL = DATA_WIDTH / 2;
    localparam int HH = DATA_WIDTH - HL;

    // input register
    logic                         r_v1;
    t_kind                        r_k1;
    logic signed [DATA_WIDTH-1:0] r_a1;
    logic signed [DATA_WIDTH-1:0] r_b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k1 <= i_kind;
            r_a1 <= i_a;
            r_b1 <= i_b;
        end
    end

    // stage a: simple ops, partial products, magnitudes
    logic                  w_bit;
    logic [DATA_WIDTH-1:0] n_simple;
    logic [HL-1:0]         w_al, w_bl;
    logic [HH-1:0]         w_ah, w_bh;
    logic [2*HL-1:0]       n_pp_ll;
    logic [HH-1:0]         n_pp_lh, n_pp_hl;
    logic [DATA_WIDTH-1:0] n_mag_a, n_mag_b;
    t_ctl                  n_ctl_a;

    always_comb begin
        w_bit    = 1'b0;
        n_simple = '0;
        unique case (r_k1)
            KIND_ADD:  n_simple = r_a1 + r_b1;
            KIND_SUB:  n_simple = r_a1 - r_b1;
            KIND_MUL:  n_simple = '0;
            KIND_DIV:  n_simple = '0;
            KIND_LT:   w_bit = r_a1 < r_b1;
            KIND_LE:   w_bit = r_a1 <= r_b1;
            KIND_EQ:   w_bit = r_a1 == r_b1;
            KIND_NE:   w_bit = r_a1 != r_b1;
            KIND_GT:   w_bit = r_a1 > r_b1;
            KIND_GE:   w_bit = r_a1 >= r_b1;
            KIND_LOR:  w_bit = (r_a1 != '0) || (r_b1 != '0);
            KIND_LAND: w_bit = (r_a1 != '0) && (r_b1 != '0);
            KIND_OR:   n_simple = r_a1 | r_b1;
            KIND_AND:  n_simple = r_a1 & r_b1;
            KIND_XOR:  n_simple = r_a1 ^ r_b1;
            KIND_NOT:  w_bit = r_a1 == '0;
        endcase
        if (w_bit) begin
            n_simple = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
        end
    end

    assign w_al = r_a1[HL-1:0];
    assign w_ah = r_a1[DATA_WIDTH-1:HL];
    assign w_bl = r_b1[HL-1:0];
    assign w_bh = r_b1[DATA_WIDTH-1:HL];

    // cross terms only matter below bit DATA_WIDTH
    assign n_pp_ll = (2*HL)'(w_al) * (2*HL)'(w_bl);
    assign n_pp_lh = HH'(w_al) * w_bh;
    assign n_pp_hl = w_ah * HH'(w_bl);

    assign n_mag_a = r_a1[DATA_WIDTH-1] ? -r_a1 : r_a1;
    assign n_mag_b = r_b1[DATA_WIDTH-1] ? -r_b1 : r_b1;

    assign n_ctl_a.valid = r_v1;
    assign n_ctl_a.kind  = r_k1;
    assign n_ctl_a.neg   = r_a1[DATA_WIDTH-1] ^ r_b1[DATA_WIDTH-1];
    assign n_ctl_a.dz    = (r_k1 == KIND_DIV) && (r_b1 == '0);

    t_ctl                  r_ctl_a;
    logic [DATA_WIDTH-1:0] r_simple_a;
    logic [2*HL-1:0]       r_pp_ll;
    logic [HH-1:0]         r_pp_lh, r_pp_hl;
    logic [DATA_WIDTH-1:0] r_mag_a_a, r_mag_b_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
        end else if (i_en) begin
            r_ctl_a <= n_ctl_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_simple_a <= n_simple;
            r_pp_ll    <= n_pp_ll;
            r_pp_lh    <= n_pp_lh;
            r_pp_hl    <= n_pp_hl;
            r_mag_a_a  <= n_mag_a;
            r_mag_b_a  <= n_mag_b;
        end
    end

    // stage b: fold partial products
    logic [HH-1:0]         w_cross;
    logic [DATA_WIDTH-1:0] w_prod;
    logic [DATA_WIDTH-1:0] n_fast;

    assign w_cross = r_pp_lh + r_pp_hl;
    assign w_prod  = DATA_WIDTH'(r_pp_ll) + {w_cross, {HL{1'b0}}};
    assign n_fast  = (r_ctl_a.kind == KIND_MUL) ? w_prod : r_simple_a;

    t_ctl                  r_ctl_b;
    logic [DATA_WIDTH-1:0] r_fast_b, r_mag_a_b, r_mag_b_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_b <= '0;
        end else if (i_en) begin
            r_ctl_b <= r_ctl_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fast_b  <= n_fast;
            r_mag_a_b <= r_mag_a_a;
            r_mag_b_b <= r_mag_b_a;
        end
    end

    assign o_ctl   = r_ctl_b;
    assign o_fast  = r_fast_b;
    assign o_mag_a = r_mag_a_b;
    assign o_mag_b = r_mag_b_b;

endmodule

`default_nettype wire

// ===== hw/rtl/iea_divider.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on iea_pkg; carries the fast-path result alongside
`default_nettype none

module iea_divider import iea_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire t_ctl                  i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_fast,
    input  wire logic [DATA_WIDTH-1:0] i_dividend,
    input  wire logic [DATA_WIDTH-1:0] i_divisor,
    output t_ctl                       o_ctl,
    output logic [DATA_WIDTH-1:0]      o_fast,
    output logic [DATA_WIDTH-1:0]      o_quot
);

    t_ctl                  r_ctl  [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] r_rem  [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] r_quo  [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] r_dvs  [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] r_fast [DATA_WIDTH];

    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
        t_ctl                  w_ctl_prev;
        logic [DATA_WIDTH-1:0] w_rem_prev, w_quo_prev, w_dvs_prev, w_fast_prev;
        logic [DATA_WIDTH:0]   w_trial, w_diff;

        if (g == 0) begin : g_first
            assign w_ctl_prev  = i_ctl;
            assign w_rem_prev  = '0;
            assign w_quo_prev  = i_dividend;
            assign w_dvs_prev  = i_divisor;
            assign w_fast_prev = i_fast;
        end else begin : g_rest
            assign w_ctl_prev  = r_ctl[g-1];
            assign w_rem_prev  = r_rem[g-1];
            assign w_quo_prev  = r_quo[g-1];
            assign w_dvs_prev  = r_dvs[g-1];
            assign w_fast_prev = r_fast[g-1];
        end

        // shift in the next dividend bit and try the subtract
        assign w_trial = {w_rem_prev, w_quo_prev[DATA_WIDTH-1]};
        assign w_diff  = w_trial - {1'b0, w_dvs_prev};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g] <= '0;
            end else if (i_en) begin
                r_ctl[g] <= w_ctl_prev;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= w_diff[DATA_WIDTH] ? w_trial[DATA_WIDTH-1:0]
                                                : w_diff[DATA_WIDTH-1:0];
                r_quo[g]  <= {w_quo_prev[DATA_WIDTH-2:0], ~w_diff[DATA_WIDTH]};
                r_dvs[g]  <= w_dvs_prev;
                r_fast[g] <= w_fast_prev;
            end
        end
    end

    assign o_ctl  = r_ctl[DATA_WIDTH-1];
    assign o_fast = r_fast[DATA_WIDTH-1];
    assign o_quot = r_quo[DATA_WIDTH-1];

endmodule

`default_nettype wire

// ===== hw/rtl/iea_out_buf.sv =====
// two-entry result buffer driving the output channel
// depends on iea_out_if; o_room gates the whole pipeline
`default_nettype none

module iea_out_buf #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr,
    input  wire logic [DATA_WIDTH-1:0] i_value,
    input  wire logic                  i_dz,
    output logic                       o_room,
    iea_out_if.source                  o_out
);

    logic [DATA_WIDTH-1:0] r_val [2];
    logic                  r_dz  [2];
    logic                  r_wr_ptr, r_rd_ptr;
    logic [1:0]            r_count;
    logic [1:0]            n_count;
    logic                  w_pop;

    assign w_pop   = o_out.valid && o_out.ready;
    assign n_count = r_count + {1'b0, i_wr} - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_val[r_wr_ptr] <= i_value;
            r_dz[r_wr_ptr]  <= i_dz;
        end
    end

    assign o_room               = r_count != 2'd2;
    assign o_out.valid          = r_count != 2'd0;
    assign o_out.value          = r_val[r_rd_ptr];
    assign o_out.divide_by_zero = r_dz[r_rd_ptr];

endmodule

`default_nettype wire

// ===== hw/rtl/integer_expression_alu_top.sv =====
// integer expression alu, top level
// uses iea_pkg, iea_in_if, iea_out_if, iea_front, iea_divider, iea_out_buf
//
// usage:
//   i_in (sink) takes one operation per transfer: kind, left_operand and
//   right_operand. o_out (source) gives one result per operation, in order:
//   value and divide_by_zero.
//   path: a result reaches o_out through the input register, two front
//   stages, DATA_WIDTH divider stages, then the output buffer. every
//   operation takes the same path, so the order never changes.
//   throughput: one operation per cycle for every kind, division included,
//   while the output buffer has room; the divider is fully pipelined with
//   one quotient bit per stage.
//   reset: i_rst_n low for one edge clears all valid bits and empties the
//   output buffer; nothing else holds state.
//   stall: the output buffer holds two results; when it is full the whole
//   pipeline freezes and i_in.ready drops, so no item is lost or repeated.
//   i_in.ready comes from a register, never from o_out.ready.
`default_nettype none

`include "integer_expression_alu_top_macros.svh"

module integer_expression_alu_top import iea_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    iea_in_if.sink    i_in,
    iea_out_if.source o_out
);

    // pipeline advance, shared by every stage
    logic w_en;

    // front end outputs
    t_ctl                  w_front_ctl;
    logic [DATA_WIDTH-1:0] w_front_fast;
    logic [DATA_WIDTH-1:0] w_mag_a, w_mag_b;

    // divider outputs
    t_ctl                  w_div_ctl;
    logic [DATA_WIDTH-1:0] w_div_fast;
    logic [DATA_WIDTH-1:0] w_quot;

    // final select
    logic [DATA_WIDTH-1:0] w_quot_signed;
    logic [DATA_WIDTH-1:0] w_value;
    logic                  w_wr;

    assign i_in.ready = w_en;

    iea_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_kind  (t_kind'(i_in.kind)),
        .i_a     (i_in.left_operand),
        .i_b     (i_in.right_operand),
        .o_ctl   (w_front_ctl),
        .o_fast  (w_front_fast),
        .o_mag_a (w_mag_a),
        .o_mag_b (w_mag_b)
    );

    iea_divider #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_ctl      (w_front_ctl),
        .i_fast     (w_front_fast),
        .i_dividend (w_mag_a),
        .i_divisor  (w_mag_b),
        .o_ctl      (w_div_ctl),
        .o_fast     (w_div_fast),
        .o_quot     (w_quot)
    );

    // restore the quotient sign; the most negative over minus one wraps on its own
    assign w_quot_signed = w_div_ctl.neg ? -w_quot : w_quot;

    // zero divisor gives zero with the flag set
    always_comb begin
        w_value = w_div_fast;
        if (w_div_ctl.kind == KIND_DIV) begin
            w_value = w_div_ctl.dz ? '0 : w_quot_signed;
        end
    end

    // the tail stage only moves when the pipeline advances
    assign w_wr = w_div_ctl.valid && w_en;

    iea_out_buf #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_value (w_value),
        .i_dz    (w_div_ctl.dz),
        .o_room  (w_en),
        .o_out   (o_out)
    );

    // a flagged division always carries a zero value
    `IEA_ASSERT_IMPL(a_dz_value_zero, o_out.valid && o_out.divide_by_zero, o_out.value == '0, "divide by zero result is not zero")
    // a frozen pipeline keeps its tail item
    `IEA_ASSERT_NEXT(a_stall_holds_tail, !w_en, $stable(w_div_ctl), "pipeline tail changed during stall")
    // a zero-divisor division leaving the tail lands in the output buffer
    `IEA_ASSERT_NEXT(a_dz_reaches_out, w_div_ctl.valid && w_div_ctl.dz && w_en, o_out.valid, "divide by zero result was dropped")

endmodule

`default_nettype wire
